// File: hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ECHC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ECHC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/echc_pkg.sv
// ---------------------------------------------------------------------------
// echc_pkg
// Types, codes and helpers for the version 3 host command engine.
// ---------------------------------------------------------------------------
`default_nettype none

package echc_pkg;

  localparam int MAX_PAYLOAD_DEF = 248;
  localparam logic [7:0] PROTO_VERSION = 8'd3;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_RESULT  = 2'd1,
    CMD_REPLY   = 2'd2,
    CMD_TIMEOUT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_EC_ERROR  = 3'd2,
    ST_BAD_VER   = 3'd3,
    ST_BAD_HDR   = 3'd4,
    ST_TOO_BIG   = 3'd5,
    ST_BAD_CSUM  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RESULT  = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    status_t     status;
    logic [7:0]  length;
    logic        last;
  } res_t;

  // one accepted item's results: a request header or one or two plain results
  typedef struct packed {
    logic        is_start;
    logic [7:0]  cmd_lo;
    logic [7:0]  cmd_hi;
    logic [7:0]  csum;
    logic        two;
    res_t        r0;
    res_t        r1;
  } bnd_t;

  function automatic res_t mk_status(status_t st, logic [7:0] data, logic [7:0] len);
    res_t r;
    r.kind      = KIND_STATUS;
    r.data_byte = data;
    r.status    = st;
    r.length    = len;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic logic [7:0] req_byte(logic [7:0] lo, logic [7:0] hi,
                                          logic [7:0] csum, logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = PROTO_VERSION;
      3'd1:    b = csum;
      3'd2:    b = lo;
      3'd3:    b = hi;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/echc_in_if.sv
// ---------------------------------------------------------------------------
// echc_in_if
// Input item channel: command, value and reply limit.
// ---------------------------------------------------------------------------
`default_nettype none

interface echc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] value;
  logic [7:0]  max_len;

  modport source (output valid, command, value, max_len, input ready);
  modport sink   (input valid, command, value, max_len, output ready);
endinterface

`default_nettype wire

// File: hdl/echc_out_if.sv
// ---------------------------------------------------------------------------
// echc_out_if
// Result item channel: request bytes, payload bytes and final status.
// ---------------------------------------------------------------------------
`default_nettype none

interface echc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] status;
  logic [7:0] length;
  logic       last;

  modport source (output valid, kind, data_byte, status, length, last, input ready);
  modport sink   (input valid, kind, data_byte, status, length, last, output ready);
endinterface

`default_nettype wire

// File: hdl/ec_host_command_v3_engine.sv
// ---------------------------------------------------------------------------
// ec_host_command_v3_engine
// Host side of the version 3 packet exchange with an embedded controller.
// ---------------------------------------------------------------------------
// in_ch carries items: start (command code, reply limit), result byte,
// reply byte, or ready timeout. out_ch carries request header bytes,
// reply payload bytes and one final status item per exchange not cut off by a new start.
// An item is taken when valid and ready are both high. Its results
// are registered into the output stage, or into the skid stage while
// the output is busy: a start gives eight request bytes, a payload
// byte gives one item, or two when it is the last one (payload then
// status). Items with no result leave the output untouched.
// Throughput is one input item per cycle while each item gives at most
// one result and the receiver is ready; the output register walks
// bundles one item per ready cycle, so after a start the next item with
// results waits in the skid stage and input stalls until it moves up.
// A stalled receiver holds the output item; one more input item with
// results is taken into the skid stage, then ready drops until the held
// bundle has gone out and the skid item has moved up.
// Synchronous reset returns the exchange to idle and empties both stages.
// ---------------------------------------------------------------------------
`default_nettype none

module ec_host_command_v3_engine
  import echc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  echc_in_if.sink    in_ch,
  echc_out_if.source out_ch
);

  logic acc;
  logic in_ready;
  logic bnd_valid;
  bnd_t bnd;

  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  echc_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .command   (in_ch.command),
    .value     (in_ch.value),
    .max_len   (in_ch.max_len),
    .bnd_valid (bnd_valid),
    .bnd       (bnd)
  );

  echc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .bnd_valid (bnd_valid),
    .bnd       (bnd),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: hdl/echc_ctrl.sv
// ---------------------------------------------------------------------------
// echc_ctrl
// Exchange state, reply header checks and result bundle for each item.
// ---------------------------------------------------------------------------
`default_nettype none

module echc_ctrl
  import echc_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        acc,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] value,
  input  wire logic [7:0]  max_len,
  output logic             bnd_valid,
  output bnd_t             bnd
);

  localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD);

  phase_t      phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  reply_version, reply_version_next;
  logic [15:0] reserved_word, reserved_word_next;
  logic [15:0] payload_len, payload_len_next;
  logic [7:0]  reply_limit, reply_limit_next;

  logic [7:0]  b;
  logic [7:0]  sum_add;
  logic [7:0]  pc_inc;
  logic [15:0] rsv_new;
  res_t        pay_res;

  assign b       = value[7:0];
  assign sum_add = running_sum + b;
  assign pc_inc  = payload_count + 8'd1;
  assign rsv_new = {b, reserved_word[7:0]};

  always_comb begin
    pay_res.kind      = KIND_PAYLOAD;
    pay_res.data_byte = b;
    pay_res.status    = ST_OK;
    pay_res.length    = 8'd0;
    pay_res.last      = 1'b0;
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    reply_version_next = reply_version;
    reserved_word_next = reserved_word;
    payload_len_next   = payload_len;
    reply_limit_next   = reply_limit;
    bnd_valid          = 1'b0;
    bnd.is_start       = 1'b0;
    bnd.cmd_lo         = value[7:0];
    bnd.cmd_hi         = value[15:8];
    bnd.csum           = 8'd0 - (PROTO_VERSION + value[7:0] + value[15:8]);
    bnd.two            = 1'b0;
    bnd.r0             = pay_res;
    bnd.r1             = mk_status(ST_OK, 8'd0, 8'd0);

    if (acc) begin
      unique case (command)
        CMD_START: begin
          bnd_valid          = 1'b1;
          bnd.is_start       = 1'b1;
          reply_limit_next   = (max_len > MaxPayload) ? MaxPayload : max_len;
          header_count_next  = 3'd0;
          payload_count_next = 8'd0;
          running_sum_next   = 8'd0;
          phase_next         = PH_RESULT;
        end
        CMD_TIMEOUT: begin
          if (phase != PH_IDLE) begin
            bnd_valid  = 1'b1;
            bnd.r0     = mk_status(ST_TIMEOUT, 8'd0, 8'd0);
            phase_next = PH_IDLE;
          end
        end
        CMD_RESULT: begin
          if (phase == PH_RESULT) begin
            if (b != 8'd0) begin
              bnd_valid  = 1'b1;
              bnd.r0     = mk_status(ST_EC_ERROR, b, 8'd0);
              phase_next = PH_IDLE;
            end else begin
              header_count_next  = 3'd0;
              running_sum_next   = 8'd0;
              reply_version_next = 8'd0;
              reserved_word_next = 16'd0;
              payload_len_next   = 16'd0;
              phase_next         = PH_HEADER;
            end
          end
        end
        default: begin
          if (phase == PH_HEADER) begin
            running_sum_next  = sum_add;
            header_count_next = header_count + 3'd1;
            case (header_count)
              3'd0: reply_version_next = b;
              3'd4: payload_len_next   = {payload_len[15:8], b};
              3'd5: payload_len_next   = {b, payload_len[7:0]};
              3'd6: reserved_word_next = {reserved_word[15:8], b};
              3'd7: reserved_word_next = rsv_new;
              default: ;
            endcase
            if (header_count == 3'd7) begin
              if (reply_version != PROTO_VERSION) begin
                bnd_valid  = 1'b1;
                bnd.r0     = mk_status(ST_BAD_VER, 8'd0, 8'd0);
                phase_next = PH_IDLE;
              end else if (rsv_new != 16'd0) begin
                bnd_valid  = 1'b1;
                bnd.r0     = mk_status(ST_BAD_HDR, 8'd0, 8'd0);
                phase_next = PH_IDLE;
              end else if (payload_len > {8'd0, reply_limit}) begin
                bnd_valid  = 1'b1;
                bnd.r0     = mk_status(ST_TOO_BIG, 8'd0, 8'd0);
                phase_next = PH_IDLE;
              end else if (payload_len == 16'd0) begin
                bnd_valid  = 1'b1;
                bnd.r0     = mk_status(ST_OK, 8'd0, 8'd0);
                phase_next = PH_IDLE;
              end else begin
                payload_count_next = 8'd0;
                phase_next         = PH_PAYLOAD;
              end
            end
          end else if (phase == PH_PAYLOAD) begin
            running_sum_next   = sum_add;
            payload_count_next = pc_inc;
            bnd_valid          = 1'b1;
            bnd.r0             = pay_res;
            if ({8'd0, pc_inc} == payload_len) begin
              bnd.two    = 1'b1;
              phase_next = PH_IDLE;
              if (sum_add != 8'd0) begin
                bnd.r1 = mk_status(ST_BAD_CSUM, 8'd0, 8'd0);
              end else begin
                bnd.r1 = mk_status(ST_OK, 8'd0, payload_len[7:0]);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= 3'd0;
      payload_count <= 8'd0;
      running_sum   <= 8'd0;
      reply_version <= 8'd0;
      reserved_word <= 16'd0;
      payload_len   <= 16'd0;
      reply_limit   <= 8'd0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      reply_version <= reply_version_next;
      reserved_word <= reserved_word_next;
      payload_len   <= payload_len_next;
      reply_limit   <= reply_limit_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/echc_emit.sv
// ---------------------------------------------------------------------------
// echc_emit
// Skid stage and output register; sends a bundle one item per ready cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module echc_emit
  import echc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  bnd_valid,
  input  wire bnd_t  bnd,
  output logic       in_ready,
  echc_out_if.source out_ch
);

  `include "assert_macros.svh"

  logic       main_valid;
  bnd_t       main;
  logic [2:0] idx;
  logic       skid_valid;
  bnd_t       skid;

  logic [2:0] last_idx;
  logic       out_fire;
  logic       main_done;
  logic       main_free;
  res_t       plain;

  assign last_idx  = main.is_start ? 3'd7 : {2'b00, main.two};
  assign out_fire  = main_valid && out_ch.ready;
  assign main_done = out_fire && (idx == last_idx);
  assign main_free = !main_valid || main_done;
  assign in_ready  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
      idx        <= 3'd0;
    end else begin
      if (main_free) begin
        idx <= 3'd0;
        if (skid_valid) begin
          main_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          main_valid <= bnd_valid;
        end
      end else begin
        if (out_fire) begin
          idx <= idx + 3'd1;
        end
        if (bnd_valid) begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main <= skid_valid ? skid : bnd;
    end
    if (!main_free && bnd_valid) begin
      skid <= bnd;
    end
  end

  assign plain = (idx == 3'd0) ? main.r0 : main.r1;

  always_comb begin
    out_ch.valid = main_valid;
    if (main.is_start) begin
      out_ch.kind      = KIND_REQUEST;
      out_ch.data_byte = req_byte(main.cmd_lo, main.cmd_hi, main.csum, idx);
      out_ch.status    = ST_OK;
      out_ch.length    = 8'd0;
      out_ch.last      = (idx == 3'd7);
    end else begin
      out_ch.kind      = plain.kind;
      out_ch.data_byte = plain.data_byte;
      out_ch.status    = plain.status;
      out_ch.length    = plain.length;
      out_ch.last      = plain.last;
    end
  end

  `ECHC_ASSERT(skid_needs_main, skid_valid |-> main_valid, "skid full with output empty")
  `ECHC_ASSERT(idx_in_range, main_valid |-> (idx <= last_idx), "item index past bundle end")
  `ECHC_ASSERT(skid_holds, (skid_valid && !main_done) |=> skid_valid, "skid item dropped")

endmodule

`default_nettype wire

// File: dv/echc_exchange_check.sv
// ---------------------------------------------------------------------------
// echc_exchange_check
// Watches both channels of the host command engine, predicts the request,
// payload and status items of every exchange and compares them in order.
// ---------------------------------------------------------------------------
module echc_exchange_check
  import echc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  echc_in_if   in_ch,
  echc_out_if  out_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_CAP = MAX_PAYLOAD_DEF;

  phase_t      ex_phase;
  logic [2:0]  hdr_idx;
  logic [7:0]  pay_count;
  logic [7:0]  byte_sum;
  logic [7:0]  reply_ver;
  logic [15:0] reply_rsvd;
  logic [15:0] reply_len;
  logic [7:0]  reply_cap;
  res_t        pending_results [$];

  function automatic void emit(kind_t k, logic [7:0] d, status_t s, logic [7:0] l,
                               logic lst);
    res_t r;
    r.kind      = k;
    r.data_byte = d;
    r.status    = s;
    r.length    = l;
    r.last      = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void close_exchange(status_t s, logic [7:0] d, logic [7:0] l);
    emit(KIND_STATUS, d, s, l, 1'b1);
    ex_phase = PH_IDLE;
  endfunction

  function automatic void clear_state();
    ex_phase   = PH_IDLE;
    hdr_idx    = '0;
    pay_count  = '0;
    byte_sum   = '0;
    reply_ver  = '0;
    reply_rsvd = '0;
    reply_len  = '0;
    reply_cap  = '0;
    pending_results.delete();
  endfunction

  function automatic void predict_exchange_step(logic [1:0] cmd, logic [15:0] v,
                                                logic [7:0] lim);
    logic [7:0] b;
    logic [7:0] csum;
    logic [7:0] req [8];
    logic       hdr_done;
    b = v[7:0];
    case (cmd)
      CMD_START: begin
        csum = 8'd0 - (PROTO_VERSION + v[7:0] + v[15:8]);
        req = '{PROTO_VERSION, csum, v[7:0], v[15:8], 8'd0, 8'd0, 8'd0, 8'd0};
        for (int i = 0; i < 8; i++) begin
          emit(KIND_REQUEST, req[i], ST_OK, 8'd0, i == 7);
        end
        reply_cap = (lim > PAYLOAD_CAP) ? 8'(PAYLOAD_CAP) : lim;
        hdr_idx   = '0;
        pay_count = '0;
        byte_sum  = '0;
        ex_phase  = PH_RESULT;
      end
      CMD_TIMEOUT: begin
        if (ex_phase != PH_IDLE) close_exchange(ST_TIMEOUT, 8'd0, 8'd0);
      end
      CMD_RESULT: begin
        if (ex_phase == PH_RESULT) begin
          if (b != 8'd0) begin
            close_exchange(ST_EC_ERROR, b, 8'd0);
          end else begin
            hdr_idx    = '0;
            byte_sum   = '0;
            reply_ver  = '0;
            reply_rsvd = '0;
            reply_len  = '0;
            ex_phase   = PH_HEADER;
          end
        end
      end
      default: begin
        if (ex_phase == PH_HEADER) begin
          byte_sum = byte_sum + b;
          case (hdr_idx)
            3'd0:    reply_ver        = b;
            3'd4:    reply_len[7:0]   = b;
            3'd5:    reply_len[15:8]  = b;
            3'd6:    reply_rsvd[7:0]  = b;
            3'd7:    reply_rsvd[15:8] = b;
            default: ;
          endcase
          hdr_done = (hdr_idx == 3'd7);
          hdr_idx  = hdr_idx + 3'd1;
          if (hdr_done) begin
            if (reply_ver != PROTO_VERSION)           close_exchange(ST_BAD_VER, 8'd0, 8'd0);
            else if (reply_rsvd != 16'd0)             close_exchange(ST_BAD_HDR, 8'd0, 8'd0);
            else if (reply_len > {8'd0, reply_cap})   close_exchange(ST_TOO_BIG, 8'd0, 8'd0);
            else if (reply_len == 16'd0)              close_exchange(ST_OK, 8'd0, 8'd0);
            else begin
              pay_count = '0;
              ex_phase  = PH_PAYLOAD;
            end
          end
        end else if (ex_phase == PH_PAYLOAD) begin
          byte_sum = byte_sum + b;
          emit(KIND_PAYLOAD, b, ST_OK, 8'd0, 1'b0);
          pay_count = pay_count + 8'd1;
          if ({8'd0, pay_count} == reply_len) begin
            if (byte_sum != 8'd0) close_exchange(ST_BAD_CSUM, 8'd0, 8'd0);
            else                  close_exchange(ST_OK, 8'd0, reply_len[7:0]);
          end
        end
      end
    endcase
  endfunction

  function automatic void report(string msg);
    if (mismatches < 10) $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endfunction

  function automatic void compare_result();
    res_t want;
    string got;
    got = $sformatf("kind %0d data %02h status %0d length %0d last %0d",
                    out_ch.kind, out_ch.data_byte, out_ch.status, out_ch.length,
                    out_ch.last);
    if (pending_results.size() == 0) begin
      report({"unexpected item: ", got});
    end else begin
      want = pending_results.pop_front();
      if (want.kind !== out_ch.kind || want.data_byte !== out_ch.data_byte ||
          want.status !== out_ch.status || want.length !== out_ch.length ||
          want.last !== out_ch.last) begin
        report($sformatf("mismatch: expected kind %0d data %02h status %0d length %0d last %0d, got %s",
                         want.kind, want.data_byte, want.status, want.length,
                         want.last, got));
      end
    end
  endfunction

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_exchange_step(in_ch.command, in_ch.value, in_ch.max_len);
      end
      if (out_ch.valid && out_ch.ready) compare_result();
    end
    outstanding = pending_results.size();
  end

endmodule

// File: dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives exchanges into the host command engine: a short directed run, then
// random exchanges with bad headers, bad sums, errors and cut-offs, under
// several sender and receiver idling mixes.
// ---------------------------------------------------------------------------
module testbench
  import echc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  int   fed;
  int   mismatches;
  int   outstanding;

  int   idle_send [4] = '{0, 80, 0, 35};
  int   idle_recv [4] = '{0, 0, 80, 35};

  echc_in_if  in_ch ();
  echc_out_if out_ch ();

  ec_host_command_v3_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  echc_exchange_check exchange_check (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send(cmd_t c, logic [15:0] v, logic [7:0] m, bit counted);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= c;
    in_ch.value   <= v;
    in_ch.max_len <= m;
    do @(posedge clk); while (!in_ch.ready);
    if (counted) fed++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic run_exchange(int want_len);
    logic [7:0]  lim;
    logic [7:0]  sat;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [7:0]  hdr [8];
    logic [7:0]  pay [$];
    logic [15:0] len;
    bit          good;
    int          n;
    int          cut;
    int          pick;
    int          i;
    lim = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(24));
    if (want_len >= 0) lim = 8'(want_len);
    sat = (lim > MAX_PAYLOAD_DEF) ? 8'(MAX_PAYLOAD_DEF) : lim;
    send(CMD_START, 16'($urandom), lim, 1);
    pick = $urandom_range(19);
    if (pick == 0) begin
      send(CMD_TIMEOUT, 16'($urandom), 8'($urandom), 1);
      return;
    end
    if (pick == 1) begin
      send(CMD_RESULT, {8'($urandom), 8'($urandom_range(1, 255))}, 8'($urandom), 1);
      return;
    end
    send(CMD_RESULT, {8'($urandom), 8'h00}, 8'($urandom), 1);

    pick = $urandom_range(19);
    if (want_len >= 0)  len = 16'(want_len);
    else if (pick == 0) len = {8'($urandom_range(1, 255)), 8'($urandom)};
    else if (pick < 3)  len = 16'(sat) + 16'($urandom_range(1, 4));
    else if (pick < 5)  len = 16'd0;
    else                len = 16'($urandom_range(0, (sat < 12) ? sat : 12));

    hdr[0] = ($urandom_range(11) == 0) ? 8'($urandom) : PROTO_VERSION;
    hdr[2] = 8'($urandom);
    hdr[3] = 8'($urandom);
    hdr[4] = len[7:0];
    hdr[5] = len[15:8];
    {hdr[7], hdr[6]} = ($urandom_range(11) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
    good = (hdr[0] == PROTO_VERSION) && ({hdr[7], hdr[6]} == 16'd0) && (len <= 16'(sat));
    // stray bytes after a rejected header are ignored by the block
    n = good ? int'(len) : $urandom_range(0, 2);

    sum = hdr[0] + hdr[2] + hdr[3] + hdr[4] + hdr[5] + hdr[6] + hdr[7];
    for (i = 0; i < n; i++) begin
      pay.push_back(8'($urandom));
      sum = sum + pay[i];
    end
    hdr[1] = 8'd0 - sum;
    if ($urandom_range(7) == 0) hdr[1] = hdr[1] ^ 8'($urandom_range(1, 255));

    cut = ($urandom_range(11) == 0) ? $urandom_range(0, 7 + n) : -1;
    for (i = 0; i < 8 + n; i++) begin
      if (i == cut) begin
        if ($urandom_range(1) == 1) send(CMD_TIMEOUT, 16'($urandom), 8'($urandom), 1);
        else                        send(CMD_START, 16'($urandom), 8'($urandom_range(24)), 1);
        return;
      end
      b = (i < 8) ? hdr[i] : pay[i - 8];
      send(CMD_REPLY, {8'($urandom), b}, 8'($urandom), (i < 8) || good);
    end
  endtask

  initial begin
    int target;
    rst          = 1'b1;
    send_idle    = 0;
    recv_stall   = 0;
    fed          = 0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_START;
    in_ch.value   <= '0;
    in_ch.max_len <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray items while idle
    send(CMD_TIMEOUT, 16'hFFFF, 8'hFF, 0);
    send(CMD_REPLY, 16'hFFFF, 8'h00, 0);
    send(CMD_RESULT, 16'h00FF, 8'hFF, 0);
    // limit saturates, empty reply skips the sum check
    send(CMD_START, 16'hFFFF, 8'hFF, 1);
    send(CMD_RESULT, 16'hFF00, 8'h00, 1);
    send(CMD_REPLY, 16'h0003, 8'h00, 1);
    send(CMD_REPLY, 16'h00AA, 8'h00, 1);
    for (int i = 0; i < 6; i++) send(CMD_REPLY, 16'hFF00, 8'hFF, 1);
    // controller error
    send(CMD_START, 16'h0000, 8'h00, 1);
    send(CMD_RESULT, 16'h00FF, 8'h00, 1);
    // timeout in result wait
    send(CMD_START, 16'h8001, 8'd248, 1);
    send(CMD_TIMEOUT, 16'h0000, 8'h00, 1);
    // start while busy, then timeout in the header
    send(CMD_START, 16'h1234, 8'd8, 1);
    send(CMD_START, 16'h4321, 8'd7, 1);
    send(CMD_RESULT, 16'h5A00, 8'h00, 1);
    send(CMD_REPLY, 16'h0003, 8'h00, 1);
    send(CMD_TIMEOUT, 16'h0000, 8'h00, 1);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle  = idle_send[p];
      recv_stall = idle_recv[p];
      target = fed + 20;
      while (fed < target) begin
        if ($urandom_range(5) == 0) begin
          send(cmd_t'($urandom_range(1, 3)), 16'($urandom), 8'($urandom), 0);
        end
        run_exchange(-1);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
